[hdl/firlp_pkg.sv]
// Package for the 72-tap low-pass FIR unit: sizes, coefficient ROM and
// the coefficient lookup function. No dependencies.
package firlp_pkg;

  localparam int TAPS         = 72;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int ACC_WIDTH    = 40;
  localparam int ROM_TAPS     = 72;
  localparam int ROM_WIDTH    = 18;

  localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W    = $clog2(TAPS + 1);
  localparam int ROM_IDX_W = $clog2(ROM_TAPS);
  localparam int FRAC      = COEF_WIDTH - 1;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int COEF_UP   = (COEF_WIDTH > ROM_WIDTH) ? COEF_WIDTH - ROM_WIDTH : 0;
  localparam int COEF_DOWN = (ROM_WIDTH > COEF_WIDTH) ? ROM_WIDTH - COEF_WIDTH : 0;
  localparam int DOWN_HALF = (COEF_DOWN > 0) ? COEF_DOWN - 1 : 0;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  localparam logic signed [ROM_WIDTH-1:0] COEF_ROM [ROM_TAPS] = '{
    -18'sd1035, -18'sd104,  -18'sd96,   -18'sd78,   -18'sd50,   -18'sd10,   18'sd43,    18'sd108,
    18'sd187,   18'sd280,   18'sd387,   18'sd508,   18'sd643,   18'sd791,   18'sd952,   18'sd1125,
    18'sd1309,  18'sd1503,  18'sd1703,  18'sd1909,  18'sd2122,  18'sd2335,  18'sd2548,  18'sd2759,
    18'sd2966,  18'sd3165,  18'sd3355,  18'sd3534,  18'sd3699,  18'sd3848,  18'sd3980,  18'sd4092,
    18'sd4184,  18'sd4253,  18'sd4300,  18'sd4324,  18'sd4324,  18'sd4300,  18'sd4253,  18'sd4184,
    18'sd4092,  18'sd3980,  18'sd3848,  18'sd3699,  18'sd3534,  18'sd3355,  18'sd3165,  18'sd2966,
    18'sd2759,  18'sd2548,  18'sd2335,  18'sd2122,  18'sd1909,  18'sd1703,  18'sd1503,  18'sd1309,
    18'sd1125,  18'sd952,   18'sd791,   18'sd643,   18'sd508,   18'sd387,   18'sd280,   18'sd187,
    18'sd108,   18'sd43,    -18'sd10,   -18'sd50,   -18'sd78,   -18'sd96,   -18'sd104,  -18'sd1035
  };

  localparam logic signed [ROM_WIDTH:0] COEF_HALF = (ROM_WIDTH + 1)'(1 << DOWN_HALF);

  // Coefficient for tap j, scaled from the ROM format to COEF_WIDTH bits.
  function automatic coef_t coef_at(input logic [TAP_IDX_W-1:0] j);
    logic signed [ROM_WIDTH:0] c;
    logic signed [ROM_WIDTH:0] r;
    c = '0;
    r = '0;
    if (int'(j) >= ROM_TAPS) begin
      return '0;
    end
    c = (ROM_WIDTH + 1)'(COEF_ROM[ROM_IDX_W'(j)]);
    if (COEF_DOWN == 0) begin
      return coef_t'(COEF_WIDTH'(c) <<< COEF_UP);
    end
    r = (c + COEF_HALF) >>> COEF_DOWN;
    return coef_t'(COEF_WIDTH'(r));
  endfunction

endpackage

[hdl/firlp_if.sv]
// Valid/ready channel interfaces for the low-pass FIR unit.
// Depends on firlp_pkg for the sample type.
interface firlp_in_if import firlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface firlp_out_if import firlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

[hdl/fir_lowpass_72tap_prefill_unit.sv]
// A beat is accepted only in the idle state; the single multiply-accumulate
// unit then steps through the history memory one tap per cycle, and the next
// beat is taken only once the result has moved to the output register.
// A finished result waits in the output register while the next beat runs.
// Reset (rst_n, synchronous) clears control only; the first sample after
// reset stands in for every history slot not yet written, so no clear pass.
module fir_lowpass_72tap_prefill_unit import firlp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  firlp_in_if.sink     in_bus,
  firlp_out_if.source  out_bus
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_FLUSH = 5'b00100,
    S_ROUND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic signed [ACC_WIDTH:0] RND_HALF = (ACC_WIDTH + 1)'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [ACC_WIDTH:0] SAT_HI   =
    (ACC_WIDTH + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_WIDTH:0] SAT_LO   = -SAT_HI - 1;
  localparam logic [TAP_IDX_W-1:0] LAST_IDX      = TAP_IDX_W'(TAPS - 1);

  state_t state_r, state_nxt;

  sample_t hist_mem [TAPS];
  sample_t rd_q_r;

  logic [TAP_IDX_W-1:0] wp_r, wp_nxt;
  logic [TAP_IDX_W-1:0] rp_r, rp_nxt;
  logic [TAP_IDX_W-1:0] ci_r, ci_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 first_r, first_nxt;
  sample_t              first_smp_r, first_smp_nxt;

  logic                 v1_r, v1_nxt;
  logic                 hit1_r;
  coef_t                coef1_r;
  logic                 v2_r, v2_nxt;
  logic signed [PROD_W-1:0] prod_r;
  acc_t                 acc_r, acc_nxt;

  sample_t              res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sample_t              out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 issue;
  logic                 out_load;
  sample_t              tap_smp;
  logic signed [ACC_WIDTH:0] rnd_sum;
  logic signed [ACC_WIDTH:0] rnd_shr;

  assign in_bus.ready         = (state_r == S_IDLE);
  assign in_acc               = in_bus.valid && in_bus.ready;
  assign issue                = (state_r == S_MAC);
  assign out_load             = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign out_bus.valid        = out_valid_r;
  assign out_bus.filtered_out = out_data_r;

  assign tap_smp = hit1_r ? rd_q_r : first_smp_r;
  assign rnd_sum = (ACC_WIDTH + 1)'(acc_r) + RND_HALF;
  assign rnd_shr = rnd_sum >>> FRAC;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_mem[wp_r] <= in_bus.sample_in;
    end
    rd_q_r <= hist_mem[rp_r];
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    ci_nxt        = ci_r;
    fill_nxt      = fill_r;
    first_nxt     = first_r;
    first_smp_nxt = first_smp_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    v1_nxt        = issue;
    v2_nxt        = v1_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (v2_r) begin
      acc_nxt = acc_r + ACC_WIDTH'(prod_r);
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wp_nxt  = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
          rp_nxt  = wp_nxt;
          ci_nxt  = LAST_IDX;
          acc_nxt = '0;
          if (int'(fill_r) < TAPS) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (first_r) begin
            first_nxt     = 1'b0;
            first_smp_nxt = in_bus.sample_in;
          end
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
        if (ci_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          ci_nxt = ci_r - 1'b1;
        end
      end
      S_FLUSH: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        priority if (rnd_shr > SAT_HI) begin
          res_nxt = sample_t'(SAT_HI);
        end else if (rnd_shr < SAT_LO) begin
          res_nxt = sample_t'(SAT_LO);
        end else begin
          res_nxt = sample_t'(rnd_shr);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      ci_r        <= '0;
      fill_r      <= '0;
      first_r     <= 1'b1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      ci_r        <= ci_nxt;
      fill_r      <= fill_nxt;
      first_r     <= first_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_smp_r <= first_smp_nxt;
    hit1_r      <= ((FILL_W + 1)'(rp_r) < (FILL_W + 1)'(fill_r));
    coef1_r     <= coef_at(ci_r);
    prod_r      <= tap_smp * coef1_r;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MAC) && (ci_r == LAST_IDX) && (acc_r == '0))
    else $error("accepted beat did not start a clean accumulation");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(fill_r) <= TAPS) && (int'(wp_r) < TAPS) && (int'(rp_r) < TAPS))
    else $error("history pointer or fill count out of range");

  a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (!v1_r && !v2_r))
    else $error("rounding started before the MAC pipeline drained");

  a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ((state_r == S_MAC) || (state_r == S_FLUSH)))
    else $error("product in flight outside the accumulation phase");

  a_fill_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    !first_r |-> (fill_r != '0))
    else $error("first sample taken but fill count is zero");

endmodule
